// ----- rtl/core/jsl_pkg.sv -----
// Shared types, codes and literal tables for the JSON scalar lexer.
// No dependencies; imported by jsl_step and json_scalar_lexer.
package jsl_pkg;

    localparam logic [3:0] PH_WS      = 4'd0;
    localparam logic [3:0] PH_LIT     = 4'd1;
    localparam logic [3:0] PH_MINUS   = 4'd2;
    localparam logic [3:0] PH_ZERO    = 4'd3;
    localparam logic [3:0] PH_INT     = 4'd4;
    localparam logic [3:0] PH_DOT     = 4'd5;
    localparam logic [3:0] PH_FRAC    = 4'd6;
    localparam logic [3:0] PH_EXP     = 4'd7;
    localparam logic [3:0] PH_EXPSIGN = 4'd8;
    localparam logic [3:0] PH_EXPDIG  = 4'd9;
    localparam logic [3:0] PH_STR     = 4'd10;
    localparam logic [3:0] PH_ESC     = 4'd11;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXPECT  = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_ESCAPE  = 3'd3;
    localparam logic [2:0] ST_QUOTE   = 3'd4;

    localparam logic [2:0] VT_NULL    = 3'd0;
    localparam logic [2:0] VT_FALSE   = 3'd1;
    localparam logic [2:0] VT_TRUE    = 3'd2;
    localparam logic [2:0] VT_NUMBER  = 3'd3;
    localparam logic [2:0] VT_STRING  = 3'd4;

    localparam logic [1:0] KIND_NULL  = 2'd0;
    localparam logic [1:0] KIND_TRUE  = 2'd1;
    localparam logic [1:0] KIND_FALSE = 2'd2;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] literal_pos;
        logic [1:0] literal_kind;
        logic       finished;
    } lex_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [2:0] status;
        logic [2:0] value_type;
    } lex_result_t;

    localparam lex_state_t LEX_STATE_RESET = '{
        phase: PH_WS, literal_pos: 3'd0, literal_kind: KIND_NULL, finished: 1'b0
    };

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == KIND_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [2:0] lit_type(input logic [1:0] kind);
        logic [2:0] vt;
        case (kind)
            KIND_TRUE:  vt = VT_TRUE;
            KIND_FALSE: vt = VT_FALSE;
            default:    vt = VT_NULL;
        endcase
        return vt;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            KIND_TRUE:
            begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            KIND_FALSE:
            begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/jsl_step.sv -----
// Next-state and result logic for one text byte of the JSON scalar lexer.
// Depends on jsl_pkg for phase, status and type codes and literal tables.
module jsl_step
    import jsl_pkg::*;
(
    input  lex_state_t  state_cur,
    input  logic        doc_start,
    input  logic [7:0]  text_byte,
    output lex_state_t  state_nxt,
    output lex_result_t result
);

    lex_state_t  st;
    lex_result_t res;
    logic [7:0]  b;
    logic [2:0]  len;
    logic [2:0]  pos_inc;

    always_comb
    begin
        st      = doc_start ? LEX_STATE_RESET : state_cur;
        b       = text_byte;
        res     = '0;
        len     = lit_len(st.literal_kind);
        pos_inc = st.literal_pos + 3'd1;

        if (!st.finished)
        begin
            case (st.phase)
                PH_WS:
                begin
                    if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D)
                    begin
                        st.phase = PH_WS;
                    end
                    else if (b == 8'h00)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_EXPECT;
                        st.finished  = 1'b1;
                    end
                    else if (b == "n" || b == "t" || b == "f")
                    begin
                        st.literal_kind = (b == "n") ? KIND_NULL :
                                          (b == "t") ? KIND_TRUE : KIND_FALSE;
                        st.literal_pos  = 3'd1;
                        st.phase        = PH_LIT;
                    end
                    else if (b == "\"")
                        st.phase = PH_STR;
                    else if (b == "-")
                        st.phase = PH_MINUS;
                    else if (b == "0")
                        st.phase = PH_ZERO;
                    else if (is_digit(b))
                        st.phase = PH_INT;
                    else
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                end
                PH_LIT:
                begin
                    if (st.literal_pos >= len || b != lit_char(st.literal_kind, st.literal_pos))
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                    else
                    begin
                        st.literal_pos = pos_inc;
                        if (pos_inc >= len)
                        begin
                            res.done_res   = 1'b1;
                            res.status     = ST_OK;
                            res.value_type = lit_type(st.literal_kind);
                            st.finished    = 1'b1;
                        end
                    end
                end
                PH_MINUS:
                begin
                    if (b == "0")
                        st.phase = PH_ZERO;
                    else if (is_digit(b))
                        st.phase = PH_INT;
                    else
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                end
                PH_ZERO, PH_INT:
                begin
                    if (is_digit(b))
                    begin
                        if (st.phase == PH_ZERO)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            st.finished  = 1'b1;
                        end
                    end
                    else if (b == ".")
                        st.phase = PH_DOT;
                    else if (b == "e" || b == "E")
                        st.phase = PH_EXP;
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.status     = ST_OK;
                        res.value_type = VT_NUMBER;
                        st.finished    = 1'b1;
                    end
                end
                PH_DOT:
                begin
                    if (is_digit(b))
                        st.phase = PH_FRAC;
                    else
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                end
                PH_FRAC:
                begin
                    if (is_digit(b))
                        st.phase = PH_FRAC;
                    else if (b == "e" || b == "E")
                        st.phase = PH_EXP;
                    else
                    begin
                        res.done_res   = 1'b1;
                        res.status     = ST_OK;
                        res.value_type = VT_NUMBER;
                        st.finished    = 1'b1;
                    end
                end
                PH_EXP:
                begin
                    if (b == "+" || b == "-")
                        st.phase = PH_EXPSIGN;
                    else if (is_digit(b))
                        st.phase = PH_EXPDIG;
                    else
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                end
                PH_EXPSIGN:
                begin
                    if (is_digit(b))
                        st.phase = PH_EXPDIG;
                    else
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_INVALID;
                        st.finished  = 1'b1;
                    end
                end
                PH_EXPDIG:
                begin
                    if (!is_digit(b))
                    begin
                        res.done_res   = 1'b1;
                        res.status     = ST_OK;
                        res.value_type = VT_NUMBER;
                        st.finished    = 1'b1;
                    end
                end
                PH_STR:
                begin
                    if (b == "\"")
                    begin
                        res.done_res   = 1'b1;
                        res.status     = ST_OK;
                        res.value_type = VT_STRING;
                        st.finished    = 1'b1;
                    end
                    else if (b == "\\")
                        st.phase = PH_ESC;
                    else if (b == 8'h00)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_QUOTE;
                        st.finished  = 1'b1;
                    end
                    else if (b < CTRL_LIMIT)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_ESCAPE;
                        st.finished  = 1'b1;
                    end
                    else
                    begin
                        res.out_byte   = b;
                        res.byte_valid = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    st.phase       = PH_STR;
                    res.byte_valid = 1'b1;
                    case (b)
                        "\"":    res.out_byte = "\"";
                        "\\":    res.out_byte = "\\";
                        "/":     res.out_byte = "/";
                        "b":     res.out_byte = 8'h08;
                        "f":     res.out_byte = 8'h0C;
                        "n":     res.out_byte = 8'h0A;
                        "r":     res.out_byte = 8'h0D;
                        "t":     res.out_byte = 8'h09;
                        default:
                        begin
                            res.byte_valid = 1'b0;
                            res.done_res   = 1'b1;
                            res.status     = ST_ESCAPE;
                            st.finished    = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_INVALID;
                    st.finished  = 1'b1;
                end
            endcase
        end

        state_nxt = st;
        result    = res;
    end

endmodule

// ----- rtl/core/json_scalar_lexer.sv -----
// JSON scalar lexer: one text byte in, one result word out, per cycle unless the output stalls.
// Path from input acceptance to result valid: input register, then result register.
// Throughput: one word per cycle; a stalled result register holds the input register.
// Reset (rst_n low, asynchronous): both stages empty, scanner in the leading whitespace phase.
// Depends on jsl_pkg and jsl_step.
module json_scalar_lexer
    import jsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       doc_start,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       done_res,
    output logic [2:0] status,
    output logic [2:0] value_type
);

    logic        in_valid_reg;
    logic        in_doc_reg;
    logic [7:0]  in_byte_reg;
    lex_state_t  state_reg;
    lex_state_t  state_next;
    logic        out_valid_reg;
    lex_result_t res_reg;
    lex_result_t res_next;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    jsl_step u_step (
        .state_cur (state_reg),
        .doc_start (in_doc_reg),
        .text_byte (in_byte_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= LEX_STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_doc_reg  <= doc_start;
            in_byte_reg <= text_byte;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = res_reg.out_byte;
    assign byte_valid = res_reg.byte_valid;
    assign done_res   = res_reg.done_res;
    assign status     = res_reg.status;
    assign value_type = res_reg.value_type;

    a_byte_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(byte_valid && done_res))
        else $error("content byte and done flag in the same word");

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK || value_type != VT_NULL)) |-> done_res)
        else $error("status or type set without done");

    a_type_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (value_type == VT_NULL))
        else $error("value type set on an error result");

    a_finished_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.done_res) |=> state_reg.finished)
        else $error("scanner not marked finished after done");

endmodule
